// ===== design/pva_pkg.sv =====
// Shared types and constants for the polyphonic voice allocator.
package pva_pkg;

    typedef enum logic [1:0] {
        OP_NOTE_ON      = 2'd0,
        OP_NOTE_OFF     = 2'd1,
        OP_VOICE_SILENT = 2'd2,
        OP_RELEASE_ALL  = 2'd3
    } op_t;

    typedef struct packed {
        op_t         operation;
        logic [6:0]  note_key;
        logic [6:0]  note_velocity;
        logic [3:0]  target_voice;
        logic [31:0] timestamp;
    } req_t;

    typedef struct packed {
        logic       found;
        logic [3:0] voice_index;
        logic       stole_voice;
    } rsp_t;

    // One voice entry as held in the voice RAM.
    typedef struct packed {
        logic [6:0]  key;
        logic [6:0]  velocity;
        logic [31:0] start_time;
        logic [31:0] release_time;
    } voice_word_t;

    localparam int WORD_W = $bits(voice_word_t);

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    // Per-voice flags held in flops, passed alongside each scanned entry.
    typedef struct packed {
        logic silent;
        logic sounding;
        logic rel_written;
    } scan_flags_t;

    typedef struct packed {
        logic have;
        logic stole;
    } sel_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

// ===== design/pva_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/pva_select.sv =====
// Running best-voice selection over the entries streamed out of the voice RAM.
module pva_select #(
    parameter int VOICES = 16
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          clear,
    input  logic                                          beat_valid,
    input  logic [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0]  beat_idx,
    input  pva_pkg::scan_flags_t                          flags,
    input  pva_pkg::voice_word_t                          word,
    input  pva_pkg::op_t                                  op,
    input  logic [6:0]                                    key,
    output pva_pkg::sel_status_t                          status,
    output logic [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0]  sel_idx,
    output pva_pkg::voice_word_t                          sel_word
);

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;

    logic                 have_reg, have_next;
    logic                 silent_hit_reg, silent_hit_next;
    logic                 stole_reg, stole_next;
    logic [1:0]           prio_reg, prio_next;
    logic [31:0]          time_reg, time_next;
    logic [IW-1:0]        idx_reg, idx_next;
    pva_pkg::voice_word_t word_reg, word_next;

    logic        key_hit;
    logic [1:0]  cand_prio;
    logic [31:0] cand_time;
    logic        take;
    logic        take_silent;

    always_comb
    begin
        key_hit   = (word.key == key);
        // released voices rank above sounding ones; same key ranks higher
        cand_prio = {~flags.sounding, key_hit};
        // an entry that was never released has no release time written; zero stands in
        cand_time = flags.sounding ? word.start_time
                  : (flags.rel_written ? word.release_time : '0);

        take        = 1'b0;
        take_silent = 1'b0;
        if (beat_valid)
        begin
            if (op == pva_pkg::OP_NOTE_ON)
            begin
                if (!silent_hit_reg)
                begin
                    if (flags.silent)
                    begin
                        take_silent = 1'b1;
                    end
                    else if (!have_reg || cand_prio > prio_reg ||
                             (cand_prio == prio_reg && cand_time < time_reg))
                    begin
                        take = 1'b1;
                    end
                end
            end
            else
            begin
                // note off: later index wins a tie, hence <=
                if (!flags.silent && flags.sounding && key_hit &&
                    word.start_time <= time_reg)
                begin
                    take = 1'b1;
                end
            end
        end

        have_next       = have_reg;
        silent_hit_next = silent_hit_reg;
        stole_next      = stole_reg;
        prio_next       = prio_reg;
        time_next       = time_reg;
        idx_next        = idx_reg;
        word_next       = word_reg;

        if (clear)
        begin
            have_next       = 1'b0;
            silent_hit_next = 1'b0;
            stole_next      = 1'b0;
            prio_next       = 2'd0;
            time_next       = pva_pkg::TIME_MAX;
        end
        else if (take_silent)
        begin
            have_next       = 1'b1;
            silent_hit_next = 1'b1;
            stole_next      = 1'b0;
            idx_next        = beat_idx;
            word_next       = word;
        end
        else if (take)
        begin
            have_next  = 1'b1;
            stole_next = (op == pva_pkg::OP_NOTE_ON);
            prio_next  = cand_prio;
            time_next  = cand_time;
            idx_next   = beat_idx;
            word_next  = word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg       <= 1'b0;
            silent_hit_reg <= 1'b0;
            stole_reg      <= 1'b0;
        end
        else
        begin
            have_reg       <= have_next;
            silent_hit_reg <= silent_hit_next;
            stole_reg      <= stole_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        time_reg <= time_next;
        idx_reg  <= idx_next;
        word_reg <= word_next;
    end

    assign status.have  = have_reg;
    assign status.stole = stole_reg;
    assign sel_idx      = idx_reg;
    assign sel_word     = word_reg;

endmodule

// ===== design/polyphonic_voice_allocator.sv =====
// Top level of the polyphonic voice allocator: control, voice flags and voice RAM.
//
// Usage
//   Requests arrive on req_valid/req_ready with one req_t beat: an operation
//   (note on, note off, voice silent, release all), key, velocity, target
//   voice and timestamp. Every request gives exactly one rsp_t beat on
//   rsp_valid/rsp_ready: found, voice index and a stolen-voice flag.
//   Voice key, velocity, start and release times live in one RAM of VOICES
//   entries; silent, sounding and release-written flags are flops.
//   Note on and note off read every voice once, one RAM read per cycle, so
//   the RAM read port sets the pace: the scan is followed by the write and
//   done states before the response is registered. Voice silent and
//   release all touch only the flags and go straight to the done state.
//   One request is in flight at a time; req_ready is high only when idle.
//   A stalled response sits in the output register and the next request is
//   still taken; its result waits until the held beat has gone.
//   Reset: all voices silent and not sounding; no RAM clearing pass is
//   needed, since the flags keep unwritten entries out of every selection.
module polyphonic_voice_allocator #(
    parameter int VOICES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  pva_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output pva_pkg::rsp_t rsp
);

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);

    // control
    pva_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            pipe_valid_reg, pipe_valid_next;
    logic [IW-1:0]   pipe_idx_reg, pipe_idx_next;
    logic            rsp_valid_reg, rsp_valid_next;

    // voice flags
    logic [VOICES-1:0] silent_reg, silent_next;
    logic [VOICES-1:0] sounding_reg, sounding_next;
    logic [VOICES-1:0] relw_reg, relw_next;

    // payload
    pva_pkg::req_t req_reg, req_next;
    pva_pkg::rsp_t res_reg, res_next;
    pva_pkg::rsp_t rsp_reg, rsp_next;

    // RAM side
    logic                 ram_re;
    logic                 ram_we;
    logic [IW-1:0]        ram_raddr;
    pva_pkg::voice_word_t ram_wdata;
    logic [pva_pkg::WORD_W-1:0] ram_rdata;

    // selection unit
    logic                 sel_clear;
    pva_pkg::scan_flags_t scan_flags;
    pva_pkg::sel_status_t sel_status;
    logic [IW-1:0]        sel_idx;
    pva_pkg::voice_word_t sel_word;

    pva_ram #(
        .WIDTH (pva_pkg::WORD_W),
        .DEPTH (VOICES)
    ) u_voice_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sel_idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign scan_flags.silent      = silent_reg[pipe_idx_reg];
    assign scan_flags.sounding    = sounding_reg[pipe_idx_reg];
    assign scan_flags.rel_written = relw_reg[pipe_idx_reg];

    pva_select #(
        .VOICES (VOICES)
    ) u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (sel_clear),
        .beat_valid (pipe_valid_reg),
        .beat_idx   (pipe_idx_reg),
        .flags      (scan_flags),
        .word       (pva_pkg::voice_word_t'(ram_rdata)),
        .op         (req_reg.operation),
        .key        (req_reg.note_key),
        .status     (sel_status),
        .sel_idx    (sel_idx),
        .sel_word   (sel_word)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pipe_valid_next = 1'b0;
        pipe_idx_next   = pipe_idx_reg;
        rsp_valid_next  = rsp_valid_reg;
        silent_next     = silent_reg;
        sounding_next   = sounding_reg;
        relw_next       = relw_reg;
        req_next        = req_reg;
        res_next        = res_reg;
        rsp_next        = rsp_reg;

        req_ready = (state_reg == pva_pkg::ST_IDLE);
        ram_re    = 1'b0;
        ram_raddr = cnt_reg[IW-1:0];
        ram_we    = 1'b0;
        ram_wdata = sel_word;
        sel_clear = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    res_next = '0;
                    unique case (req.operation)
                        pva_pkg::OP_NOTE_ON, pva_pkg::OP_NOTE_OFF:
                        begin
                            cnt_next   = '0;
                            sel_clear  = 1'b1;
                            state_next = pva_pkg::ST_SCAN;
                        end
                        pva_pkg::OP_VOICE_SILENT:
                        begin
                            if (32'(req.target_voice) < 32'(VOICES))
                            begin
                                silent_next[IW'(req.target_voice)] = 1'b1;
                                res_next.found       = 1'b1;
                                res_next.voice_index = req.target_voice;
                            end
                            state_next = pva_pkg::ST_DONE;
                        end
                        pva_pkg::OP_RELEASE_ALL:
                        begin
                            sounding_next = '0;
                            state_next    = pva_pkg::ST_DONE;
                        end
                        default:
                        begin
                            state_next = pva_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            pva_pkg::ST_SCAN:
            begin
                // issue one read per cycle; data reaches the selector in the next cycle
                if (cnt_reg < CW'(VOICES))
                begin
                    ram_re          = 1'b1;
                    cnt_next        = cnt_reg + 1'b1;
                    pipe_valid_next = 1'b1;
                    pipe_idx_next   = cnt_reg[IW-1:0];
                end
                if (pipe_valid_reg && pipe_idx_reg == IW'(VOICES - 1))
                begin
                    state_next = pva_pkg::ST_WRITE;
                end
            end

            pva_pkg::ST_WRITE:
            begin
                res_next = '0;
                if (sel_status.have)
                begin
                    ram_we = 1'b1;
                    if (req_reg.operation == pva_pkg::OP_NOTE_ON)
                    begin
                        ram_wdata.key        = req_reg.note_key;
                        ram_wdata.velocity   = req_reg.note_velocity;
                        ram_wdata.start_time = req_reg.timestamp;
                        silent_next[sel_idx]   = 1'b0;
                        sounding_next[sel_idx] = 1'b1;
                    end
                    else
                    begin
                        ram_wdata.release_time = req_reg.timestamp;
                        sounding_next[sel_idx] = 1'b0;
                        relw_next[sel_idx]     = 1'b1;
                    end
                    res_next.found       = 1'b1;
                    res_next.voice_index = 4'(sel_idx);
                    res_next.stole_voice = sel_status.stole;
                end
                state_next = pva_pkg::ST_DONE;
            end

            pva_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = pva_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pva_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pva_pkg::ST_IDLE;
            cnt_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            pipe_idx_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            silent_reg     <= '1;
            sounding_reg   <= '0;
            relw_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pipe_valid_reg <= pipe_valid_next;
            pipe_idx_reg   <= pipe_idx_next;
            rsp_valid_reg  <= rsp_valid_next;
            silent_reg     <= silent_next;
            sounding_reg   <= sounding_next;
            relw_reg       <= relw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== design/pva_checker.sv =====
// Port-level checks for the polyphonic voice allocator, bound to the top level.
module pva_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input pva_pkg::rsp_t rsp
);

    // one request in flight: no second beat straight after a taken one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one still in flight");

    // a held response keeps its beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed or dropped");

    // no voice found means nothing else to report
    a_not_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.voice_index == 4'd0 && !rsp.stole_voice)
        else $error("response without a voice carries index or steal flag");

    // a steal always names a voice
    a_steal_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.stole_voice |-> rsp.found)
        else $error("steal flag without a found voice");

endmodule

bind polyphonic_voice_allocator pva_checker u_pva_checker (.*);

// ===== test/tb_polyphonic_voice_allocator.sv =====
// Self-checking testbench for the polyphonic voice allocator.
`timescale 1ns / 1ps

module tb_polyphonic_voice_allocator;

    localparam int VOICES      = 16;
    // The longest legal quiet spell, a sender gap, a scan and a response
    // stall together, stays far below this limit.
    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    pva_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    pva_pkg::rsp_t rsp;

    polyphonic_voice_allocator #(
        .VOICES(VOICES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Voice table mirror, updated once per accepted request beat.
    // ------------------------------------------------------------------
    logic        voice_idle     [VOICES];
    logic        voice_held     [VOICES];
    logic [6:0]  voice_note     [VOICES];
    logic [6:0]  voice_vel      [VOICES];
    logic [31:0] voice_on_time  [VOICES];
    logic [31:0] voice_off_time [VOICES];

    pva_pkg::rsp_t pending_allocs[$];
    int   mismatch_count = 0;
    int   stall_cycles   = 0;
    bit   idle_on        = 1'b1;
    logic [31:0] clock_ts = '0;

    // A held voice ages from its start; a released one from its release.
    function automatic logic [31:0] voice_age_ref(int v);
        return voice_held[v] ? voice_on_time[v] : voice_off_time[v];
    endfunction

    function automatic pva_pkg::rsp_t predict_allocation(pva_pkg::req_t r);
        pva_pkg::rsp_t res;
        int          sel;
        bit          have;
        bit          took_free;
        logic [1:0]  prio;
        logic [1:0]  best;
        logic [31:0] earliest;
        res       = '0;
        sel       = 0;
        have      = 1'b0;
        took_free = 1'b0;
        best      = '0;
        case (r.operation)
            pva_pkg::OP_NOTE_ON:
            begin
                // First silent voice wins outright; otherwise steal by priority:
                // released over held, matching key over other keys, oldest first.
                for (int v = 0; v < VOICES && !took_free; v++)
                begin
                    if (voice_idle[v])
                    begin
                        sel             = v;
                        have            = 1'b1;
                        took_free       = 1'b1;
                        res.stole_voice = 1'b0;
                    end
                    else
                    begin
                        prio = {~voice_held[v], voice_note[v] == r.note_key};
                        if (!have || prio > best ||
                            (prio == best && voice_age_ref(v) < voice_age_ref(sel)))
                        begin
                            sel             = v;
                            best            = prio;
                            have            = 1'b1;
                            res.stole_voice = 1'b1;
                        end
                    end
                end
                voice_idle[sel]    = 1'b0;
                voice_held[sel]    = 1'b1;
                voice_note[sel]    = r.note_key;
                voice_vel[sel]     = r.note_velocity;
                voice_on_time[sel] = r.timestamp;
                res.found          = 1'b1;
                res.voice_index    = 4'(sel);
            end
            pva_pkg::OP_NOTE_OFF:
            begin
                // Earliest start wins; <= lets the higher index take a tie.
                earliest = pva_pkg::TIME_MAX;
                for (int v = 0; v < VOICES; v++)
                begin
                    if (!voice_idle[v] && voice_held[v] && voice_note[v] == r.note_key &&
                        voice_on_time[v] <= earliest)
                    begin
                        earliest = voice_on_time[v];
                        sel      = v;
                        have     = 1'b1;
                    end
                end
                if (have)
                begin
                    voice_held[sel]     = 1'b0;
                    voice_off_time[sel] = r.timestamp;
                    res.found           = 1'b1;
                    res.voice_index     = 4'(sel);
                end
            end
            pva_pkg::OP_VOICE_SILENT:
            begin
                if (int'(r.target_voice) < VOICES)
                begin
                    voice_idle[r.target_voice] = 1'b1;
                    res.found                  = 1'b1;
                    res.voice_index            = r.target_voice;
                end
            end
            default:
            begin
                // Release all: only the held flags change.
                for (int v = 0; v < VOICES; v++)
                    voice_held[v] = 1'b0;
            end
        endcase
        return res;
    endfunction

    initial
    begin
        for (int v = 0; v < VOICES; v++)
        begin
            voice_idle[v]     = 1'b1;
            voice_held[v]     = 1'b0;
            voice_note[v]     = '0;
            voice_vel[v]      = '0;
            voice_on_time[v]  = '0;
            voice_off_time[v] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each response beat against the oldest prediction,
    // then predicts from any request beat taken at the same edge. The
    // response always belongs to an earlier request, so this order is safe.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pva_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pending_allocs.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected response beat: found=%0b voice=%0d stole=%0b",
                                 rsp.found, rsp.voice_index, rsp.stole_voice);
                end
                else
                begin
                    want = pending_allocs.pop_front();
                    if (rsp.found !== want.found || rsp.voice_index !== want.voice_index ||
                        rsp.stole_voice !== want.stole_voice)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected found=%0b voice=%0d stole=%0b, %s",
                                     want.found, want.voice_index, want.stole_voice,
                                     $sformatf("got found=%0b voice=%0d stole=%0b",
                                               rsp.found, rsp.voice_index, rsp.stole_voice));
                    end
                end
            end
            if (req_valid && req_ready)
                pending_allocs.push_back(predict_allocation(req));
        end
    end

    // Watchdog: too long with no beat on either channel means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("** polyphonic_voice_allocator: FAILED **");
                $finish;
            end
        end
    end

    // Response back-pressure in random bursts while idling is on.
    always
    begin
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        rsp_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Sender. Called just after a falling edge; returns just after the
    // falling edge that follows acceptance, with valid still high so that a
    // back-to-back beat keeps valid high throughout.
    // ------------------------------------------------------------------
    function automatic pva_pkg::req_t make_event(pva_pkg::op_t op, logic [6:0] key,
                                                 logic [6:0] vel, logic [3:0] target,
                                                 logic [31:0] ts);
        pva_pkg::req_t r;
        r.operation     = op;
        r.note_key      = key;
        r.note_velocity = vel;
        r.target_voice  = target;
        r.timestamp     = ts;
        return r;
    endfunction

    task automatic send_event(input pva_pkg::req_t item);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sender holds off until the allocator has answered everything.
    task automatic hold_until_drained();
        req_valid <= 1'b0;
        while (pending_allocs.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Fill every voice, then steal: held with the same key, then the oldest held.
    task automatic test_fill_and_steal();
        for (int v = 0; v < VOICES; v++)
            send_event(make_event(pva_pkg::OP_NOTE_ON,
                                  (v == VOICES - 1) ? 7'd127 : 7'(v * 8),
                                  v[0] ? 7'd127 : 7'd0, 4'(v),
                                  (v == VOICES - 1) ? pva_pkg::TIME_MAX : 32'(v * 10)));
        send_event(make_event(pva_pkg::OP_NOTE_ON, 7'd40, 7'd64, 4'd0, 32'd500));
        send_event(make_event(pva_pkg::OP_NOTE_ON, 7'd50, 7'd64, 4'd0, 32'd510));
    endtask

    // Release two voices, reuse them (same key first), and miss on a free key.
    task automatic test_note_off();
        send_event(make_event(pva_pkg::OP_NOTE_OFF, 7'd8,   7'd0,  4'd15, 32'd600));
        send_event(make_event(pva_pkg::OP_NOTE_OFF, 7'd16,  7'd0,  4'd0,  32'd550));
        send_event(make_event(pva_pkg::OP_NOTE_ON,  7'd8,   7'd33, 4'd0,  32'd700));
        send_event(make_event(pva_pkg::OP_NOTE_ON,  7'd99,  7'd90, 4'd0,  32'd710));
        send_event(make_event(pva_pkg::OP_NOTE_OFF, 7'd100, 7'd0,  4'd0,  32'd720));
    endtask

    // Silence the end voices, restart both on one key and time: note off
    // must then release the higher index.
    task automatic test_voice_silent();
        send_event(make_event(pva_pkg::OP_VOICE_SILENT, 7'd0,  7'd0,  4'd0,  32'd800));
        send_event(make_event(pva_pkg::OP_VOICE_SILENT, 7'd0,  7'd0,  4'd15, 32'd810));
        send_event(make_event(pva_pkg::OP_NOTE_ON,      7'd77, 7'd10, 4'd0,  32'd900));
        send_event(make_event(pva_pkg::OP_NOTE_ON,      7'd77, 7'd20, 4'd0,  32'd900));
        send_event(make_event(pva_pkg::OP_NOTE_OFF,     7'd77, 7'd0,  4'd0,  32'd950));
    endtask

    // Release all leaves stale release times; the next steal goes by them.
    task automatic test_release_all();
        send_event(make_event(pva_pkg::OP_RELEASE_ALL, 7'd127, 7'd127, 4'd15,
                              pva_pkg::TIME_MAX));
        send_event(make_event(pva_pkg::OP_NOTE_ON,     7'd1,   7'd5,   4'd0,  32'd1000));
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly note on/off over a narrow key range so that
    // keys collide and every steal priority is hit, some silencing, and
    // the odd release all. Time mostly creeps forward, with ties and jumps.
    // ------------------------------------------------------------------
    task automatic test_random_traffic(input int count);
        pva_pkg::op_t op;
        logic [6:0]  key;
        logic [31:0] ts;
        int          pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                op = pva_pkg::OP_NOTE_ON;
            else if (pick < 80)
                op = pva_pkg::OP_NOTE_OFF;
            else if (pick < 95)
                op = pva_pkg::OP_VOICE_SILENT;
            else
                op = pva_pkg::OP_RELEASE_ALL;
            key = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(60, 67))
                                             : 7'($urandom_range(0, 127));
            case ($urandom_range(0, 19))
                0:       ts = $urandom();
                1:       ts = clock_ts;
                default:
                begin
                    clock_ts = clock_ts + 32'($urandom_range(1, 50));
                    ts       = clock_ts;
                end
            endcase
            send_event(make_event(op, key, 7'($urandom_range(0, 127)),
                                  4'($urandom_range(0, 15)), ts));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_fill_and_steal();
        test_note_off();
        test_voice_silent();
        test_release_all();
        test_random_traffic(1000);
        hold_until_drained();
        test_random_traffic(700);
        // Closing stretch at full rate on both sides.
        idle_on = 1'b0;
        test_random_traffic(300);

        req_valid <= 1'b0;
        while (pending_allocs.size() != 0)
            @(posedge clk);
        repeat (VOICES + 8) @(posedge clk);

        if (mismatch_count == 0 && pending_allocs.size() == 0)
            $display("** polyphonic_voice_allocator: PASSED **");
        else
            $display("** polyphonic_voice_allocator: FAILED **");
        $finish;
    end

endmodule
